@@ rtl/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_WIDTH  = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * MAG_WIDTH;
   localparam int DIV_WIDTH  = 2 * DATA_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE       = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_LAST   = 2'd2;

   typedef enum logic [2:0] {
      STATUS_INTERP = 3'd0,
      STATUS_EXACT  = 3'd1,
      STATUS_BEFORE = 3'd2,
      STATUS_PAST   = 3'd3,
      STATUS_EMPTY  = 3'd4,
      STATUS_SAT    = 3'd5
   } status_type;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

@@ rtl/pli_ram.sv @@
`timescale 1ns / 1ps

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/pli_alu.sv @@
`timescale 1ns / 1ps

module pli_alu import pli_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_cmd_type           cmd,
   input  logic [DIV_WIDTH-1:0]  opa,
   input  logic [MAG_WIDTH-1:0]  opb,
   output logic                  done,
   output logic [PROD_WIDTH-1:0] product,
   output logic [DIV_WIDTH-1:0]  quotient
);

   localparam int CW = $clog2(DIV_WIDTH + 1);

   logic [MAG_WIDTH:0]   hi_ff;
   logic [DIV_WIDTH-1:0] lo_ff;
   logic [MAG_WIDTH-1:0] b_ff;
   alu_op_type           op_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [MAG_WIDTH:0]   x;
   logic [MAG_WIDTH:0]   y;
   logic [MAG_WIDTH+1:0] sum;

   // one shared adder: add for shift-add multiply, subtract for restoring divide
   always_comb begin
      if (op_ff == ALU_MUL) begin
         x = hi_ff;
         y = lo_ff[0] ? {1'b0, b_ff} : '0;
      end else begin
         x = {hi_ff[MAG_WIDTH-1:0], lo_ff[DIV_WIDTH-1]};
         y = ~{1'b0, b_ff};
      end
      sum = {1'b0, x} + {1'b0, y} + {{(MAG_WIDTH+1){1'b0}}, (op_ff == ALU_DIV)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !cmd.start && busy_ff && cnt_ff == CW'(1);
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         b_ff   <= opb;
         hi_ff  <= '0;
         lo_ff  <= opa;
         cnt_ff <= (cmd.op == ALU_MUL) ? CW'(MAG_WIDTH) : CW'(DIV_WIDTH);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (op_ff == ALU_MUL) begin
            hi_ff <= {1'b0, sum[MAG_WIDTH:1]};
            lo_ff <= {sum[0], lo_ff[DIV_WIDTH-1:1]};
         end else begin
            if (sum[MAG_WIDTH+1]) begin
               hi_ff <= sum[MAG_WIDTH:0];
            end else begin
               hi_ff <= {hi_ff[MAG_WIDTH-1:0], lo_ff[DIV_WIDTH-1]};
            end
            lo_ff <= {lo_ff[DIV_WIDTH-2:0], sum[MAG_WIDTH+1]};
         end
      end
   end

   assign done     = done_ff;
   assign product  = {hi_ff[MAG_WIDTH-1:0], lo_ff[DIV_WIDTH-1 -: MAG_WIDTH]};
   assign quotient = lo_ff;

endmodule

@@ rtl/piecewise_linear_table_interp_top.sv @@
`timescale 1ns / 1ps

// Piecewise-linear breakpoint table with a remembered interval cursor.
// Request channel (req_*): kind 0 writes one breakpoint (time, value) to slot
// point_index; kind 1 queries the table at query_time. A write beat gives no
// response and the block is ready again in the next cycle.
// Response channel (rsp_*): one beat per query with factor (signed Q16.16,
// scaled and saturated) and status.
// Control writes (csr_*): point_count, scale_factor, hold_last; write only
// while no query is in flight.
// An empty-table query goes straight to the output register; else it reads the
// cursor point and walks one point per read. A zero answer needs no arithmetic,
// an exact point or the held last value is scaled, and an interpolation over a
// nonzero interval is multiplied and divided first. One shared add/subtract unit
// does a 33-step multiply, a 65-step divide and a 33-step scaling multiply.
// req_stall is high from a query beat until its response is loaded into the
// output register. A response held by rsp_stall keeps its payload; the next
// request is taken meanwhile, and a later response waits behind it.
// Reset clears the cursor, the control registers (scale 1.0) and the channels;
// table contents are undefined until written.

module piecewise_linear_table_interp_top import pli_pkg::*; #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [9:0]                 req_point_index,
   input  logic signed [DATA_WIDTH-1:0] req_point_time,
   input  logic signed [DATA_WIDTH-1:0] req_point_value,
   input  logic signed [DATA_WIDTH-1:0] req_query_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_factor,
   output logic [2:0]                 rsp_status,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int QW = DATA_WIDTH + 2;
   localparam int SW = DATA_WIDTH + 4;
   localparam logic [QW-1:0] QUOT_LIMIT = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [SW-1:0] SUM_MAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DIV_WIDTH-1:0] RES_MAX =
      {{(DIV_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DIV_WIDTH-1:0] RES_MIN =
      {{(DIV_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_T1_WAIT, S_T1, S_FWD_WAIT, S_FWD, S_BWD_WAIT, S_BWD, S_PAST,
      S_LAST_WAIT, S_LAST, S_INTERP, S_MUL, S_DIV, S_SCALE, S_SCALE_MUL, S_OUT
   } state_type;

   state_type                    state_ff;
   logic [10:0]                  point_count_ff;
   logic signed [DATA_WIDTH-1:0] scale_ff;
   logic                         hold_ff;
   logic [AW-1:0]                cursor_ff;
   logic signed [DATA_WIDTH-1:0] q_ff;
   logic [NW-1:0]                n_ff;
   logic [AW-1:0]                c_ff;
   logic [AW-1:0]                addr_ff;
   logic signed [DATA_WIDTH-1:0] t1_ff, t2_ff, v1_ff, v2_ff, val_ff;
   status_type                   status_ff;
   logic                         sat_ff;
   logic                         neg_ff;
   logic [MAG_WIDTH-1:0]         dt_mag_ff;
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_factor_ff;
   logic [2:0]                   rsp_status_ff;

   logic [DATA_WIDTH-1:0]        t_rdata, v_rdata;
   logic signed [DATA_WIDTH-1:0] t_rd, v_rd;
   logic                         tbl_we;
   logic                         req_take;
   logic [NW-1:0]                n_calc;
   logic [AW-1:0]                c_calc;
   logic signed [MAG_WIDTH-1:0]  dt_w, dv_w, dq_w;
   logic [MAG_WIDTH-1:0]         dt_mag, dv_mag, dq_mag, val_mag, scale_mag;
   logic                         interp_neg;
   logic [QW-1:0]                quot_cl;
   logic signed [SW-1:0]         sum_base, sum_q, sum_v;
   logic [2*DATA_WIDTH-1:0]      prod_mag;
   logic signed [DIV_WIDTH-1:0]  prod_s, res_s;
   alu_cmd_type                  alu_cmd;
   logic [DIV_WIDTH-1:0]         alu_opa;
   logic [MAG_WIDTH-1:0]         alu_opb;
   logic                         alu_done;
   logic [PROD_WIDTH-1:0]        alu_prod;
   logic [DIV_WIDTH-1:0]         alu_quot;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign tbl_we    = req_take && (req_kind == KIND_WRITE) &&
                      (int'(req_point_index) < MAX_POINTS);

   pli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_POINTS)) u_time_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_point_index[AW-1:0]),
      .wdata (req_point_time),
      .raddr (addr_ff),
      .rdata (t_rdata)
   );

   pli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_POINTS)) u_value_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_point_index[AW-1:0]),
      .wdata (req_point_value),
      .raddr (addr_ff),
      .rdata (v_rdata)
   );

   pli_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (alu_cmd),
      .opa      (alu_opa),
      .opb      (alu_opb),
      .done     (alu_done),
      .product  (alu_prod),
      .quotient (alu_quot)
   );

   always_comb begin
      t_rd = $signed(t_rdata);
      v_rd = $signed(v_rdata);

      n_calc = (int'(point_count_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count_ff);
      c_calc = (int'(cursor_ff) > int'(n_calc) - 1) ? AW'(n_calc - NW'(1)) : cursor_ff;

      dt_w = {t2_ff[DATA_WIDTH-1], t2_ff} - {t1_ff[DATA_WIDTH-1], t1_ff};
      dv_w = {v2_ff[DATA_WIDTH-1], v2_ff} - {v1_ff[DATA_WIDTH-1], v1_ff};
      dq_w = {q_ff[DATA_WIDTH-1], q_ff} - {t1_ff[DATA_WIDTH-1], t1_ff};
      dt_mag = dt_w[MAG_WIDTH-1] ? MAG_WIDTH'(-dt_w) : MAG_WIDTH'(dt_w);
      dv_mag = dv_w[MAG_WIDTH-1] ? MAG_WIDTH'(-dv_w) : MAG_WIDTH'(dv_w);
      dq_mag = dq_w[MAG_WIDTH-1] ? MAG_WIDTH'(-dq_w) : MAG_WIDTH'(dq_w);
      interp_neg = dv_w[MAG_WIDTH-1] ^ dq_w[MAG_WIDTH-1] ^ dt_w[MAG_WIDTH-1];

      val_mag   = val_ff[DATA_WIDTH-1] ? MAG_WIDTH'(-{1'b1, val_ff}) : {1'b0, val_ff};
      scale_mag = scale_ff[DATA_WIDTH-1] ? MAG_WIDTH'(-{1'b1, scale_ff}) : {1'b0, scale_ff};

      quot_cl  = (alu_quot > {{(DIV_WIDTH-QW){1'b0}}, QUOT_LIMIT}) ? QUOT_LIMIT
                                                                 : alu_quot[QW-1:0];
      sum_base = {{(SW-DATA_WIDTH){v1_ff[DATA_WIDTH-1]}}, v1_ff};
      sum_q    = {{(SW-QW){1'b0}}, quot_cl};
      sum_v    = neg_ff ? (sum_base - sum_q) : (sum_base + sum_q);

      prod_mag = alu_prod[2*DATA_WIDTH-1:0];
      prod_s   = neg_ff ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
      res_s    = prod_s >>> FRAC_BITS;

      alu_cmd.start = 1'b0;
      alu_cmd.op    = ALU_MUL;
      alu_opa       = {{(DIV_WIDTH-MAG_WIDTH){1'b0}}, dv_mag};
      alu_opb       = dq_mag;
      unique case (state_ff)
         S_INTERP: begin
            alu_cmd.start = (dt_w != '0);
         end
         S_MUL: begin
            alu_cmd.start = alu_done;
            alu_cmd.op    = ALU_DIV;
            alu_opa       = alu_prod[DIV_WIDTH-1:0];
            alu_opb       = dt_mag_ff;
         end
         S_SCALE: begin
            alu_cmd.start = 1'b1;
            alu_opa       = {{(DIV_WIDTH-MAG_WIDTH){1'b0}}, val_mag};
            alu_opb       = scale_mag;
         end
         default: begin
            alu_cmd.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         point_count_ff <= '0;
         scale_ff       <= 32'sd65536;
         hold_ff        <= 1'b0;
         cursor_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POINT_COUNT: point_count_ff <= csr_wdata[10:0];
               CSR_SCALE:       scale_ff       <= $signed(csr_wdata);
               CSR_HOLD_LAST:   hold_ff        <= csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take && req_kind == KIND_QUERY) begin
                  q_ff   <= req_query_time;
                  n_ff   <= n_calc;
                  sat_ff <= 1'b0;
                  val_ff <= '0;
                  if (n_calc == '0) begin
                     status_ff <= STATUS_EMPTY;
                     c_ff      <= cursor_ff;
                     state_ff  <= S_OUT;
                  end else begin
                     c_ff     <= c_calc;
                     addr_ff  <= c_calc;
                     state_ff <= S_T1_WAIT;
                  end
               end
            end
            S_T1_WAIT: state_ff <= S_T1;
            S_T1: begin
               t1_ff <= t_rd;
               v1_ff <= v_rd;
               if (q_ff < t_rd && c_ff == '0) begin
                  status_ff <= STATUS_BEFORE;
                  state_ff  <= S_OUT;
               end else if (q_ff == t_rd) begin
                  val_ff    <= v_rd;
                  status_ff <= STATUS_EXACT;
                  state_ff  <= S_SCALE;
               end else if (q_ff > t_rd) begin
                  if (NW'(c_ff) == n_ff - NW'(1)) begin
                     state_ff <= S_PAST;
                  end else begin
                     addr_ff  <= c_ff + AW'(1);
                     state_ff <= S_FWD_WAIT;
                  end
               end else begin
                  t2_ff    <= t_rd;
                  v2_ff    <= v_rd;
                  c_ff     <= c_ff - AW'(1);
                  addr_ff  <= c_ff - AW'(1);
                  state_ff <= S_BWD_WAIT;
               end
            end
            S_FWD_WAIT: state_ff <= S_FWD;
            S_FWD: begin
               if (q_ff > t_rd && ((NW+1)'(c_ff) + (NW+1)'(2) < (NW+1)'(n_ff))) begin
                  t1_ff    <= t_rd;
                  v1_ff    <= v_rd;
                  c_ff     <= c_ff + AW'(1);
                  addr_ff  <= c_ff + AW'(2);
                  state_ff <= S_FWD_WAIT;
               end else if (q_ff > t_rd) begin
                  state_ff <= S_PAST;
               end else begin
                  t2_ff    <= t_rd;
                  v2_ff    <= v_rd;
                  state_ff <= S_INTERP;
               end
            end
            S_BWD_WAIT: state_ff <= S_BWD;
            S_BWD: begin
               if (q_ff < t_rd && c_ff != '0) begin
                  t2_ff    <= t_rd;
                  v2_ff    <= v_rd;
                  c_ff     <= c_ff - AW'(1);
                  addr_ff  <= c_ff - AW'(1);
                  state_ff <= S_BWD_WAIT;
               end else if (q_ff < t_rd) begin
                  status_ff <= STATUS_BEFORE;
                  state_ff  <= S_OUT;
               end else begin
                  t1_ff    <= t_rd;
                  v1_ff    <= v_rd;
                  state_ff <= S_INTERP;
               end
            end
            S_PAST: begin
               status_ff <= STATUS_PAST;
               if (hold_ff) begin
                  addr_ff  <= AW'(n_ff - NW'(1));
                  state_ff <= S_LAST_WAIT;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_LAST_WAIT: state_ff <= S_LAST;
            S_LAST: begin
               val_ff   <= v_rd;
               state_ff <= S_SCALE;
            end
            S_INTERP: begin
               status_ff <= STATUS_INTERP;
               neg_ff    <= interp_neg;
               dt_mag_ff <= dt_mag;
               if (dt_w == '0) begin
                  val_ff   <= v1_ff;
                  state_ff <= S_SCALE;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (alu_done) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (alu_done) begin
                  if (sum_v > SUM_MAX) begin
                     val_ff <= SUM_MAX[DATA_WIDTH-1:0];
                     sat_ff <= 1'b1;
                  end else if (sum_v < SUM_MIN) begin
                     val_ff <= SUM_MIN[DATA_WIDTH-1:0];
                     sat_ff <= 1'b1;
                  end else begin
                     val_ff <= sum_v[DATA_WIDTH-1:0];
                  end
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               neg_ff   <= val_ff[DATA_WIDTH-1] ^ scale_ff[DATA_WIDTH-1];
               state_ff <= S_SCALE_MUL;
            end
            S_SCALE_MUL: begin
               if (alu_done) begin
                  if (res_s > RES_MAX) begin
                     val_ff <= RES_MAX[DATA_WIDTH-1:0];
                     sat_ff <= 1'b1;
                  end else if (res_s < RES_MIN) begin
                     val_ff <= RES_MIN[DATA_WIDTH-1:0];
                     sat_ff <= 1'b1;
                  end else begin
                     val_ff <= res_s[DATA_WIDTH-1:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_factor_ff <= val_ff;
                  rsp_status_ff <= sat_ff ? STATUS_SAT : status_ff;
                  cursor_ff     <= c_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ rtl/pli_checker.sv @@
`timescale 1ns / 1ps

module pli_checker import pli_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [DATA_WIDTH-1:0]  rsp_factor,
   input logic [2:0]                    rsp_status
);

   // no response beat comes out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_factor) && $stable(rsp_status))
      else $error("stalled response beat changed");

   // a query beat makes the request side busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_QUERY |=> req_stall)
      else $error("request taken right after a query");

   // an empty table or a query before the first point carries a zero factor
   a_zero_cases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BEFORE || rsp_status == STATUS_EMPTY)
      |-> rsp_factor == '0)
      else $error("nonzero factor for empty table or before start");

   // status code range
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_SAT)
      else $error("undefined status code");

endmodule

bind piecewise_linear_table_interp_top pli_checker u_pli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_kind   (req_kind),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_factor (rsp_factor),
   .rsp_status (rsp_status)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import pli_pkg::*;

   localparam int  TABLE_DEPTH = 1024;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  RANDOM_ITEMS = 495;
   localparam int  SETTLE_CYCLES = 40;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] factor;
      status_type                   status;
   } factor_result_type;

   class factor_scoreboard;
      longint            t_tab[TABLE_DEPTH];
      longint            v_tab[TABLE_DEPTH];
      int unsigned       cursor;
      int unsigned       count;
      longint            scale;
      bit                hold;
      bit                sat_hit;
      int                errors;
      factor_result_type waiting[$];

      function new();
         cursor = 0;
         count = 0;
         scale = 65536;
         hold = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] data);
         if (idx == CSR_POINT_COUNT) count = data[10:0];
         else if (idx == CSR_SCALE) scale = longint'($signed(data));
         else if (idx == CSR_HOLD_LAST) hold = data[0];
      endfunction

      function longint clamp(longint v);
         longint hi, lo;
         hi = 64'sd2147483647;
         lo = -64'sd2147483648;
         if (v > hi) begin
            sat_hit = 1;
            return hi;
         end
         if (v < lo) begin
            sat_hit = 1;
            return lo;
         end
         return v;
      endfunction

      function longint scaled(longint v);
         longint p;
         p = v * scale;
         return clamp(p >>> FRAC_BITS);
      endfunction

      function longint lerp(longint q, longint t1, longint t2, longint v1, longint v2);
         longint     dv, dq, dt;
         bit [66:0]  mdv, mdq, mdt, quot;
         bit         neg;
         dv = v2 - v1;
         dq = q - t1;
         dt = t2 - t1;
         if (dt == 0) return v1;
         mdv = dv < 0 ? -dv : dv;
         mdq = dq < 0 ? -dq : dq;
         mdt = dt < 0 ? -dt : dt;
         quot = (mdv * mdq) / mdt;
         if (quot > (67'd1 << 33)) quot = 67'd1 << 33;
         neg = ((dv < 0) != (dq < 0)) != (dt < 0);
         return clamp(neg ? v1 - longint'(quot) : v1 + longint'(quot));
      endfunction

      function void note_beat(logic kind, logic [9:0] idx, logic [DATA_WIDTH-1:0] pt,
                              logic [DATA_WIDTH-1:0] pv, logic [DATA_WIDTH-1:0] qt);
         int unsigned       n, c;
         longint            q, t1, t2, res;
         status_type        st;
         factor_result_type r;
         if (kind == KIND_WRITE) begin
            t_tab[idx] = longint'($signed(pt));
            v_tab[idx] = longint'($signed(pv));
            return;
         end
         sat_hit = 0;
         res = 0;
         q = longint'($signed(qt));
         n = count > TABLE_DEPTH ? TABLE_DEPTH : count;
         if (n == 0) begin
            r.factor = 0;
            r.status = STATUS_EMPTY;
            waiting.push_back(r);
            return;
         end
         c = cursor > n - 1 ? n - 1 : cursor;
         t1 = t_tab[c];
         if (q < t1 && c == 0) begin
            st = STATUS_BEFORE;
         end else if (q == t1) begin
            res = scaled(v_tab[c]);
            st = STATUS_EXACT;
         end else if (q > t1) begin
            if (c == n - 1) begin
               st = STATUS_PAST;
            end else begin
               t2 = t_tab[c + 1];
               while (q > t2 && c + 2 < n) begin
                  c++;
                  t1 = t2;
                  t2 = t_tab[c + 1];
               end
               if (q > t2) begin
                  st = STATUS_PAST;
               end else begin
                  res = scaled(lerp(q, t1, t2, v_tab[c], v_tab[c + 1]));
                  st = STATUS_INTERP;
               end
            end
            if (st == STATUS_PAST && hold) res = scaled(v_tab[n - 1]);
         end else begin
            t2 = t1;
            while (q < t1 && c > 0) begin
               c--;
               t2 = t1;
               t1 = t_tab[c];
            end
            if (q < t1) begin
               st = STATUS_BEFORE;
            end else begin
               res = scaled(lerp(q, t1, t2, v_tab[c], v_tab[c + 1]));
               st = STATUS_INTERP;
            end
         end
         cursor = c;
         if (sat_hit) st = STATUS_SAT;
         r.factor = res[DATA_WIDTH-1:0];
         r.status = st;
         waiting.push_back(r);
      endfunction

      function void check_beat(logic [DATA_WIDTH-1:0] factor, logic [2:0] status);
         factor_result_type e;
         if (waiting.size() == 0) begin
            $error("response beat with nothing expected: factor %h status %0d", factor, status);
            errors++;
            return;
         end
         e = waiting.pop_front();
         if (factor !== e.factor) begin
            $error("factor: expected %h, got %h", e.factor, factor);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_valid = 0;
   logic                          req_stall;
   logic                          req_kind = 0;
   logic [9:0]                    req_point_index = 0;
   logic signed [DATA_WIDTH-1:0]  req_point_time = 0;
   logic signed [DATA_WIDTH-1:0]  req_point_value = 0;
   logic signed [DATA_WIDTH-1:0]  req_query_time = 0;
   logic                          rsp_valid;
   logic                          rsp_stall = 0;
   logic signed [DATA_WIDTH-1:0]  rsp_factor;
   logic [2:0]                    rsp_status;
   logic                          csr_we = 0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = 0;
   logic [DATA_WIDTH-1:0]         csr_wdata = 0;

   factor_scoreboard sb = new();
   bit               calm = 0;
   int               cycles = 0;
   int               filled = 0;
   int               random_items = 0;
   int               times[$];
   int               n_pts;

   piecewise_linear_table_interp_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_point_index(req_point_index), .req_point_time(req_point_time),
      .req_point_value(req_point_value), .req_query_time(req_query_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_factor(rsp_factor),
      .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_factor, rsp_status);
   end

   always @(negedge clock) rsp_stall = calm ? 1'b0 : ($urandom_range(99) < 15);

   task automatic send(logic kind, logic [9:0] idx, logic [DATA_WIDTH-1:0] pt,
                       logic [DATA_WIDTH-1:0] pv, logic [DATA_WIDTH-1:0] qt);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_kind = kind;
      req_point_index = idx;
      req_point_time = pt;
      req_point_value = pv;
      req_query_time = qt;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_beat(kind, idx, pt, pv, qt);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_point(int idx, int t, int v);
      send(KIND_WRITE, idx[9:0], t, v, $urandom);
      if (idx == filled) filled++;
   endtask

   task automatic query(int q);
      send(KIND_QUERY, 10'($urandom), $urandom, $urandom, q);
   endtask

   task automatic drain();
      while (sb.waiting.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] data);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
      sb.set_reg(idx, data);
   endtask

   function automatic int pick_time();
      int     k;
      longint lo, hi;
      k = $urandom_range(n_pts - 1);
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            lo = times[k];
            hi = k < n_pts - 1 ? times[k + 1] : lo + $urandom_range(1000);
            if (hi <= lo) return int'(lo);
            return int'(lo + (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff)
                        % (hi - lo + 1));
         end
         4, 5: return times[k];
         6: return int'(longint'(times[0]) - $urandom_range(1, 70000));
         7: return int'(longint'(times[n_pts - 1]) + $urandom_range(1, 70000));
         8: return $urandom;
         default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   // a time between the first and the last loaded point of a sorted table
   function automatic int pick_inside();
      longint lo, hi;
      lo = times[0];
      hi = times[n_pts - 1];
      return int'(lo + (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff) % (hi - lo + 1));
   endfunction

   function automatic int pick_scale();
      case ($urandom_range(7))
         0, 1: return 65536;
         2: return -65536;
         3: return 32'h7fff_ffff;
         4: return 32'h8000_0000;
         5: return 0;
         6: return $urandom_range(1 << 18) - (1 << 17);
         default: return $urandom;
      endcase
   endfunction

   task automatic load_table(int n, bit wide, bit unsorted);
      int tmp, j;
      times.delete();
      if (wide) begin
         repeat (n) times.push_back($urandom);
         times.sort();
      end else begin
         tmp = $signed($urandom) >>> 4;
         repeat (n) begin
            times.push_back(tmp);
            tmp += $urandom_range(9) == 0 ? 0 : $urandom_range(1, 200000);
         end
      end
      if (unsorted) times.shuffle();
      n_pts = n;
      for (j = 0; j < n; j++)
         write_point(j, times[j], $urandom_range(1) ? $urandom
                                                     : $urandom_range(1 << 22) - (1 << 21));
      drain();
   endtask

   initial begin
      int k, nq, n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, extremes, walks, hold, saturation, cursor clamp
      query(32'h8000_0000);
      write_point(0, -(1 << 30), 32'h8000_0000);
      write_point(1, 0, 32'h7fff_ffff);
      write_point(2, 65536, 100);
      write_point(3, 1 << 30, -(5 << 16));
      times = '{-(1 << 30), 0, 65536, 1 << 30};
      n_pts = 4;
      drain();
      set_reg(CSR_POINT_COUNT, 4);
      query(32'h8000_0000);
      query(-(1 << 30));
      query(32768);
      query(1 << 30);
      query(32'h7fff_ffff);
      drain();
      set_reg(CSR_HOLD_LAST, 1);
      query(32'h7fff_ffff);
      query(-100);
      query(-(1 << 30) + 7);
      drain();
      set_reg(CSR_SCALE, 32'h7fff_ffff);
      query(0);
      query(40000);
      drain();
      set_reg(CSR_SCALE, 32'h8000_0000);
      query(-(1 << 30));
      query(1 << 29);
      query(2000000000);
      drain();
      set_reg(CSR_POINT_COUNT, 2);
      query(123456);
      drain();

      // random phases
      while (random_items < RANDOM_ITEMS) begin
         n = $urandom_range(9) == 0 ? 1 : $urandom_range(2, 16);
         load_table(n, $urandom_range(1), $urandom_range(99) < 15);
         random_items += n;
         set_reg(CSR_POINT_COUNT, n);
         set_reg(CSR_SCALE, pick_scale());
         set_reg(CSR_HOLD_LAST, $urandom_range(1));
         calm = $urandom_range(5) == 0;
         nq = $urandom_range(15, 40);
         for (k = 0; k < nq; k++) begin
            if ($urandom_range(9) == 0) write_point($urandom_range(n - 1), $urandom, $urandom);
            else query(pick_time());
            if (k == nq / 2 && $urandom_range(3) == 0) drain();
            random_items++;
         end
         calm = 0;
         drain();
      end

      // count register at the table depth and with all bits set, walks kept in loaded points
      load_table(16, 0, 0);
      for (k = 0; k < 6; k++) begin
         set_reg(CSR_POINT_COUNT, k[0] ? 32'h7ff : 32'd1024);
         set_reg(CSR_HOLD_LAST, 32'(k[1]));
         set_reg(CSR_SCALE, pick_scale());
         query(pick_inside());
         query(times[0] - 1);
         query(times[n_pts - 1]);
         drain();
      end

      drain();
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
